[hw/rtl/xsenc_pkg.sv]
// Package: block mapping constants, job type and character mapping function.
package xsenc_pkg;

    localparam int CharsMax  = 9;
    localparam int CountW    = $clog2(CharsMax + 1);
    localparam int BlockW    = 20;
    localparam int GroupLast = 4;

    localparam logic [7:0] CharAmp   = 8'h26;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharQuery = 8'h3f;
    localparam logic [7:0] CharDigit = 8'h30;

    typedef logic [CharsMax-1:0][7:0] t_chars;

    typedef struct packed {
        logic              has_a;
        logic [BlockW-1:0] word_a;
        logic              has_b;
        logic [BlockW-1:0] word_b;
        logic              term;
        logic [2:0]        rest;
        logic              eos;
    } t_job;

    function automatic logic [7:0] fix_char(input logic [7:0] c);
        return (c == CharAmp) ? CharTab : c;
    endfunction

    // map one 20-bit block to three characters
    function automatic logic [23:0] map_block(input logic [BlockW-1:0] blk);
        logic [31:0] w;
        logic [31:0] o;
        w = {blk, 12'h000};
        if ((w & 32'h03efd000) == 32'h01e3c000) begin
            o = 32'h38404000 | ((w & 32'h00100000) << 5) | ((w & 32'h00002000) << 11)
              | ((w & 32'hfc000000) >> 10);
        end else if ((w & 32'h03e80000) == 32'h01e00000) begin
            o = 32'h30404000 | ((w & 32'h00100000) << 5) | ((w & 32'h00001000) << 12)
              | ((w & 32'hfc000000) >> 10) | ((w & 32'h0007e000) >> 5);
        end else if ((w & 32'h0007d000) == 32'h0003c000) begin
            o = 32'h34404000 | ((w & 32'h00002000) << 12) | ((w & 32'h00080000) << 5)
              | ((w & 32'hfc000000) >> 10) | ((w & 32'h03f00000) >> 12);
        end else if ((w & 32'h03000000) != 32'h0 && (w & 32'h00060000) != 32'h0) begin
            o = 32'h40000000 | ((w & 32'hfc000000) >> 2) | ((w & 32'h03f80000) >> 3)
              | ((w & 32'h0007f000) >> 4);
        end else if ((w & 32'hf3000000) == 32'h0) begin
            o = 32'h20204000 | (w & 32'h0c000000) | ((w & 32'h00c00000) << 2)
              | ((w & 32'h003c0000) >> 2) | ((w & 32'h0003f000) >> 4);
        end else if ((w & 32'hf0060000) == 32'h0) begin
            o = 32'h20402000 | ((w & 32'h00010000) << 11) | ((w & 32'h0e000000) >> 1)
              | ((w & 32'h01f80000) >> 3) | ((w & 32'h0000f000) >> 4);
        end else if ((w & 32'h03060000) == 32'h0) begin
            o = 32'h20404000 | ((w & 32'hf0000000) >> 4) | ((w & 32'h0c000000) >> 6)
              | ((w & 32'h00f00000) >> 4) | ((w & 32'h00080000) >> 6)
              | ((w & 32'h0001f000) >> 4);
        end else if ((w & 32'h03000000) == 32'h0) begin
            o = 32'h00c08000 | ((w & 32'h0007f000) << 12) | ((w & 32'hf8000000) >> 11)
              | ((w & 32'h00080000) >> 6) | ((w & 32'h04000000) >> 14)
              | ((w & 32'h00f00000) >> 12);
        end else begin
            o = 32'hc0800000 | ((w & 32'hf8000000) >> 3) | ((w & 32'h04000000) >> 5)
              | ((w & 32'h0001f000) << 4) | ((w & 32'h03f80000) >> 11);
        end
        return {fix_char(o[31:24]), fix_char(o[23:16]), fix_char(o[15:8])};
    endfunction

endpackage

[hw/rtl/xsenc_pack.sv]
// Character packer: maps the blocks of one job and lines up its characters in order.
module xsenc_pack (
    input  xsenc_pkg::t_job                   i_job,
    output xsenc_pkg::t_chars                 o_chars,
    output logic [xsenc_pkg::CountW-1:0]      o_count
);
    import xsenc_pkg::*;

    logic [23:0]       chars_a;
    logic [23:0]       chars_b;
    logic [CountW-1:0] slot;

    assign chars_a = map_block(i_job.word_a);
    assign chars_b = map_block(i_job.word_b);

    always_comb begin
        o_chars = '0;
        slot    = '0;
        if (i_job.has_a) begin
            o_chars[slot]          = chars_a[23:16];
            o_chars[slot + 4'd1]   = chars_a[15:8];
            o_chars[slot + 4'd2]   = chars_a[7:0];
            slot                   = slot + 4'd3;
        end
        if (i_job.has_b) begin
            o_chars[slot]          = chars_b[23:16];
            o_chars[slot + 4'd1]   = chars_b[15:8];
            o_chars[slot + 4'd2]   = chars_b[7:0];
            slot                   = slot + 4'd3;
        end
        if (i_job.term) begin
            o_chars[slot]          = CharQuery;
            o_chars[slot + 4'd1]   = CharDigit | {5'b0, i_job.rest};
            o_chars[slot + 4'd2]   = CharQuery;
            slot                   = slot + 4'd3;
        end
        o_count = slot;
    end

endmodule

[hw/rtl/xml_safe_binary_to_text_encoder.sv]
// Top level: byte stream to text-safe character encoder.
//
//  channel | direction | handshake                    | beat payload
//  input   | in        | i_in_valid / o_in_stall      | i_data_byte, i_end_of_stream
//  output  | out       | o_out_valid / i_out_stall    | o_text_char, o_last_char
//
// A byte is taken into a job register; once the buffer is free, the job's blocks are
// mapped and loaded into a 9-character shift buffer, and one character leaves per cycle
// while the output is not stalled. Sustained rate is set by the output port: six
// characters per five bytes; bytes that yield no character never load the buffer.
// Synchronous active-low reset clears group position, job valid and buffer count.
// Output stall holds the buffer; input stall rises when a job waits on a busy buffer.
module xml_safe_binary_to_text_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_text_char,
    output logic       o_last_char
);
    import xsenc_pkg::*;

    logic [2:0]        r_pos;
    logic [2:0]        n_pos;
    logic [7:0]        r_pend [4];
    logic              r_jv;
    t_job              r_job;
    t_job              n_job;
    t_chars            r_chars;
    logic [CountW-1:0] r_cnt;
    logic              r_eos;
    t_chars            pk_chars;
    logic [CountW-1:0] pk_count;
    logic [2:0]        pos;
    logic              in_fire;
    logic              out_fire;
    logic              buf_free;
    logic              load;
    logic              job_chars;

    assign pos      = (r_pos > 3'(GroupLast)) ? 3'd0 : r_pos;
    assign out_fire = o_out_valid && !i_out_stall;
    assign buf_free = (r_cnt == '0) || ((r_cnt == CountW'(1)) && out_fire);
    assign load     = r_jv && buf_free;
    assign o_in_stall = r_jv && !buf_free;
    assign in_fire  = i_in_valid && !o_in_stall;

    always_comb begin
        n_job        = '0;
        n_job.eos    = i_end_of_stream;
        n_job.rest   = pos + 3'd1;
        n_job.term   = i_end_of_stream && (pos != 3'(GroupLast));
        case (pos)
            3'd0: begin
                n_job.has_a  = i_end_of_stream;
                n_job.word_a = {i_data_byte, 12'h000};
            end
            3'd1: begin
                n_job.has_a  = i_end_of_stream;
                n_job.word_a = {r_pend[0], i_data_byte, 4'h0};
            end
            3'd2: begin
                n_job.has_a  = 1'b1;
                n_job.word_a = {r_pend[0], r_pend[1], i_data_byte[7:4]};
                n_job.has_b  = i_end_of_stream;
                n_job.word_b = {i_data_byte[3:0], 16'h0000};
            end
            3'd3: begin
                n_job.has_b  = i_end_of_stream;
                n_job.word_b = {r_pend[2][3:0], i_data_byte, 8'h00};
            end
            default: begin
                n_job.has_b  = 1'b1;
                n_job.word_b = {r_pend[2][3:0], r_pend[3], i_data_byte};
            end
        endcase
        job_chars = n_job.has_a || n_job.has_b || n_job.term;
        n_pos     = (i_end_of_stream || pos == 3'(GroupLast)) ? 3'd0 : pos + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_jv  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_pos <= n_pos;
                r_jv  <= job_chars;
            end else if (load) begin
                r_jv  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_job <= n_job;
            if (pos != 3'(GroupLast)) begin
                r_pend[pos[1:0]] <= i_data_byte;
            end
        end
    end

    xsenc_pack u_pack (
        .i_job   (r_job),
        .o_chars (pk_chars),
        .o_count (pk_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= pk_count;
        end else if (out_fire) begin
            r_cnt <= r_cnt - CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chars <= pk_chars;
            r_eos   <= r_job.eos;
        end else if (out_fire) begin
            r_chars <= {8'h00, r_chars[CharsMax-1:1]};
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_text_char = r_chars[0];
    assign o_last_char = r_eos && (r_cnt == CountW'(1));

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CountW'(CharsMax))
        else $error("character count beyond buffer depth");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 3'(GroupLast))
        else $error("group position out of range");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_last_char && !r_jv) |=> !o_out_valid)
        else $error("characters remain after final beat");

    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_jv && !buf_free) |=> (r_jv && $stable(r_job)))
        else $error("waiting job lost");
`endif

endmodule

[tb/tb_top.sv]
// Testbench for the byte stream to text-safe encoder: directed and random streams.
module tb_top;
    import xsenc_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 16;
    localparam int HoldCycles  = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_stream = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_text_char;
    logic       o_last_char;

    int unsigned send_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    int unsigned fail_cnt = 0;
    int unsigned cycle_cnt = 0;

    logic [2:0] grp_pos = 3'd0;
    logic [7:0] held_byte [4];
    logic [7:0] burst [$];
    t_char      chars_due [$];
    t_char      due_char;

    xml_safe_binary_to_text_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_text_char     (o_text_char),
        .o_last_char     (o_last_char)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles, %0d chars still due", cycle_cnt,
                     chars_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    function automatic logic [23:0] encode_block(input logic [19:0] blk);
        logic [31:0] w;
        logic [31:0] t;
        logic [23:0] chars;
        w = {blk, 12'h000};
        if ((w & 32'h03efd000) == 32'h01e3c000) begin
            t = 32'h38404000 | ((w & 32'h00100000) << 5) | ((w & 32'h00002000) << 11)
              | ((w & 32'hfc000000) >> 10);
        end else if ((w & 32'h03e80000) == 32'h01e00000) begin
            t = 32'h30404000 | ((w & 32'h00100000) << 5) | ((w & 32'h00001000) << 12)
              | ((w & 32'hfc000000) >> 10) | ((w & 32'h0007e000) >> 5);
        end else if ((w & 32'h0007d000) == 32'h0003c000) begin
            t = 32'h34404000 | ((w & 32'h00002000) << 12) | ((w & 32'h00080000) << 5)
              | ((w & 32'hfc000000) >> 10) | ((w & 32'h03f00000) >> 12);
        end else if ((w & 32'h03000000) != 0 && (w & 32'h00060000) != 0) begin
            t = 32'h40000000 | ((w & 32'hfc000000) >> 2) | ((w & 32'h03f80000) >> 3)
              | ((w & 32'h0007f000) >> 4);
        end else if ((w & 32'hf3000000) == 0) begin
            t = 32'h20204000 | (w & 32'h0c000000) | ((w & 32'h00c00000) << 2)
              | ((w & 32'h003c0000) >> 2) | ((w & 32'h0003f000) >> 4);
        end else if ((w & 32'hf0060000) == 0) begin
            t = 32'h20402000 | ((w & 32'h00010000) << 11) | ((w & 32'h0e000000) >> 1)
              | ((w & 32'h01f80000) >> 3) | ((w & 32'h0000f000) >> 4);
        end else if ((w & 32'h03060000) == 0) begin
            t = 32'h20404000 | ((w & 32'hf0000000) >> 4) | ((w & 32'h0c000000) >> 6)
              | ((w & 32'h00f00000) >> 4) | ((w & 32'h00080000) >> 6)
              | ((w & 32'h0001f000) >> 4);
        end else if ((w & 32'h03000000) == 0) begin
            t = 32'h00c08000 | ((w & 32'h0007f000) << 12) | ((w & 32'hf8000000) >> 11)
              | ((w & 32'h00080000) >> 6) | ((w & 32'h04000000) >> 14)
              | ((w & 32'h00f00000) >> 12);
        end else begin
            t = 32'hc0800000 | ((w & 32'hf8000000) >> 3) | ((w & 32'h04000000) >> 5)
              | ((w & 32'h0001f000) << 4) | ((w & 32'h03f80000) >> 11);
        end
        chars = t[31:8];
        for (int k = 0; k < 3; k++) begin
            if (chars[8*k +: 8] == CharAmp) begin
                chars[8*k +: 8] = CharTab;
            end
        end
        return chars;
    endfunction

    task automatic add_block(input logic [19:0] blk);
        logic [23:0] chars;
        chars = encode_block(blk);
        burst.push_back(chars[23:16]);
        burst.push_back(chars[15:8]);
        burst.push_back(chars[7:0]);
    endtask

    task automatic predict_text(input logic [7:0] b, input logic eos);
        logic [2:0] pos;
        logic [2:0] rest;
        t_char      c;
        pos = (grp_pos > 3'd4) ? 3'd0 : grp_pos;
        burst.delete();
        case (pos)
            3'd0: begin
                held_byte[0] = b;
                if (eos) add_block({b, 12'h000});
            end
            3'd1: begin
                held_byte[1] = b;
                if (eos) add_block({held_byte[0], b, 4'h0});
            end
            3'd2: begin
                held_byte[2] = b;
                add_block({held_byte[0], held_byte[1], b[7:4]});
                if (eos) add_block({b[3:0], 16'h0000});
            end
            3'd3: begin
                held_byte[3] = b;
                if (eos) add_block({held_byte[2][3:0], b, 8'h00});
            end
            default: begin
                add_block({held_byte[2][3:0], held_byte[3], b});
            end
        endcase
        rest = (pos == 3'd4) ? 3'd0 : pos + 3'd1;
        if (eos && rest != 3'd0) begin
            burst.push_back(CharQuery);
            burst.push_back(CharDigit | {5'd0, rest});
            burst.push_back(CharQuery);
        end
        for (int k = 0; k < burst.size(); k++) begin
            c.ch = burst[k];
            c.last = eos && (k == burst.size() - 1);
            chars_due.push_back(c);
        end
        grp_pos = (eos || pos == 3'd4) ? 3'd0 : pos + 3'd1;
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_cnt, what);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (chars_due.size() == 0) begin
                report_mismatch($sformatf("unexpected char %02h last %0b",
                                          o_text_char, o_last_char));
            end else begin
                due_char = chars_due.pop_front();
                if (o_text_char !== due_char.ch) begin
                    report_mismatch($sformatf("text_char %02h, want %02h",
                                              o_text_char, due_char.ch));
                end
                if (o_last_char !== due_char.last) begin
                    report_mismatch($sformatf("last_char %0b, want %0b on char %02h",
                                              o_last_char, due_char.last, due_char.ch));
                end
            end
        end
    end

    // call and return at a falling edge; valid stays high into the next beat
    task automatic send_beat(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_in_stall);
        predict_text(b, eos);
        @(negedge i_clk);
    endtask

    task automatic send_group(input logic [19:0] blk_a, input logic [19:0] blk_b,
                              input logic eos);
        send_beat(blk_a[19:12], 1'b0);
        send_beat(blk_a[11:4], 1'b0);
        send_beat({blk_a[3:0], blk_b[19:16]}, 1'b0);
        send_beat(blk_b[15:8], 1'b0);
        send_beat(blk_b[7:0], eos);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_stream(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_beat(pick_byte(), i == len - 1);
        end
    endtask

    task automatic test_stream_ends();
        send_beat(8'h00, 1'b1);
        send_beat(8'hff, 1'b0);
        send_beat(8'hff, 1'b1);
        send_beat(8'hff, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'hff, 1'b1);
    endtask

    task automatic test_block_cases();
        send_group(20'h01e3c, 20'h01e00, 1'b0);
        send_group(20'h0003c, 20'h01020, 1'b0);
        send_group(20'h04800, 20'h01000, 1'b0);
        send_group(20'h10000, 20'h10020, 1'b1);
        // end on the third byte of a group: both blocks plus termination
        send_beat(8'h11, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h0f, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned n_bytes);
        int unsigned sent;
        int unsigned len;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            send_stream(len);
            sent += len;
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_req = HoldCycles;
        send_stream(17);
        send_stream(13);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_stream_ends();
        test_block_cases();
        test_random_traffic(0, 0, 100);
        test_random_traffic(61, 0, 100);
        test_random_traffic(0, 61, 100);
        test_random_traffic(23, 23, 100);
        test_output_backpressure();
        i_in_valid <= 1'b0;
        while (chars_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
